>>> hdl/tnc_pkg.sv
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared types and constants of the tag nesting checker: status codes,
// classified operation kinds, queue entry layout and register indexes.
// ----------------------------------------------------------------------------
package tnc_pkg;

   // field widths fixed by the interface
   localparam int NAME_W   = 16;
   localparam int DEPTH_W  = 7;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 3;
   localparam int INDEX_W  = 3;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam logic [INDEX_W-1:0] CSR_RELEVANT_COUNT = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_TAG_BASE       = 3'd1;

   // document status reported with each result
   typedef enum logic [STATUS_W-1:0] {
      ST_RUNNING  = 3'd0,
      ST_OK       = 3'd1,
      ST_UNCLOSED = 3'd2,
      ST_TOO_DEEP = 3'd3,
      ST_NO_OPEN  = 3'd4,
      ST_MISMATCH = 3'd5
   } status_type;

   // what the back end has to do with one item
   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,   // skipped tag or no flags
      OP_OPEN  = 3'd1,
      OP_CLOSE = 3'd2,
      OP_SELF  = 3'd3,   // self-closing tag
      OP_EOD   = 3'd4
   } op_type;

   // one classified item in the queue
   typedef struct packed {
      op_type            kind;
      logic [NAME_W-1:0] name;
   } item_type;

   // back end sequencer
   typedef enum logic {
      B_IDLE = 1'b0,
      B_CMP  = 1'b1
   } back_state_type;

endpackage

>>> hdl/tnc_ram.sv
// ----------------------------------------------------------------------------
// tnc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tnc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hdl/tnc_front.sv
// ----------------------------------------------------------------------------
// tnc_front
// Configuration registers and item classification: checks the tag against
// the relevant list and turns the flags into one operation for the back end.
// ----------------------------------------------------------------------------
module tnc_front #(
   parameter int RELEVANT_SLOTS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tnc_pkg::INDEX_W-1:0]   csr_index,
   input  logic [tnc_pkg::NAME_W-1:0]    csr_wdata,
   // incoming item
   input  logic                          req_end_of_doc,
   input  logic [tnc_pkg::NAME_W-1:0]    req_tag_name,
   input  logic                          req_is_open,
   input  logic                          req_is_close,
   // classified item toward the queue
   output tnc_pkg::item_type             item
);

   logic [tnc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [tnc_pkg::NAME_W-1:0]  tag_ff [RELEVANT_SLOTS];
   logic [tnc_pkg::NAME_W-1:0]  tag_in [RELEVANT_SLOTS];
   logic                        csr_wr;
   logic                        hit;
   logic                        counts;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // register writes; indexes beyond the slots are dropped
   always_comb begin
      count_in = count_ff;
      for (int s = 0; s < RELEVANT_SLOTS; s++) begin
         tag_in[s] = tag_ff[s];
      end
      if (csr_wr) begin
         if (csr_index == tnc_pkg::CSR_RELEVANT_COUNT) begin
            count_in = csr_wdata[tnc_pkg::COUNT_W-1:0];
         end
         for (int s = 0; s < RELEVANT_SLOTS; s++) begin
            if (csr_index == tnc_pkg::CSR_TAG_BASE + tnc_pkg::INDEX_W'(s)) begin
               tag_in[s] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int s = 0; s < RELEVANT_SLOTS; s++) begin
            tag_ff[s] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int s = 0; s < RELEVANT_SLOTS; s++) begin
            tag_ff[s] <= tag_in[s];
         end
      end
   end

   // relevance check; a count above the slot number uses all slots
   always_comb begin
      hit = 1'b0;
      for (int s = 0; s < RELEVANT_SLOTS; s++) begin
         if ((tnc_pkg::COUNT_W'(s) < count_ff) && (tag_ff[s] == req_tag_name)) begin
            hit = 1'b1;
         end
      end
   end

   assign counts = (count_ff == '0) | hit;

   // classification
   always_comb begin
      item.name = req_tag_name;
      priority if (req_end_of_doc) begin
         item.kind = tnc_pkg::OP_EOD;
      end else if (!counts) begin
         item.kind = tnc_pkg::OP_NOP;
      end else if (req_is_open && req_is_close) begin
         item.kind = tnc_pkg::OP_SELF;
      end else if (req_is_open) begin
         item.kind = tnc_pkg::OP_OPEN;
      end else if (req_is_close) begin
         item.kind = tnc_pkg::OP_CLOSE;
      end else begin
         item.kind = tnc_pkg::OP_NOP;
      end
   end

endmodule

>>> hdl/tnc_queue.sv
// ----------------------------------------------------------------------------
// tnc_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module tnc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tnc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output tnc_pkg::item_type head
);

   localparam int QD  = tnc_pkg::QUEUE_DEPTH;
   localparam int QAW = $clog2(QD);
   localparam int QCW = $clog2(QD + 1);

   tnc_pkg::item_type entry_ff [QD];
   logic [QAW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]    count_ff, count_in;

   assign full  = (count_ff == QCW'(QD));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCW'(push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("queue popped while empty");

endmodule

>>> hdl/tnc_back.sv
// ----------------------------------------------------------------------------
// tnc_back
// Stack engine: carries out one classified item at a time, keeps depth,
// peak, held error and the bottom entry in registers, and drives results.
// ----------------------------------------------------------------------------
module tnc_back #(
   parameter int STACK_DEPTH = 100
) (
   input  logic                           clock,
   input  logic                           reset,
   // queue head
   input  logic                           q_valid,
   input  tnc_pkg::item_type              q_item,
   output logic                           q_pop,
   // result
   output logic                           rsp_strobe,
   output logic [tnc_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tnc_pkg::DEPTH_W-1:0]    rsp_depth,
   output logic [tnc_pkg::DEPTH_W-1:0]    rsp_max_depth,
   output logic [tnc_pkg::NAME_W-1:0]     rsp_error_tag
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   tnc_pkg::back_state_type    state_ff, state_in;
   logic [CW-1:0]              top_ff, top_in;
   logic [CW-1:0]              peak_ff, peak_in;
   tnc_pkg::status_type        status_ff, status_in;
   logic [tnc_pkg::NAME_W-1:0] etag_ff, etag_in;
   logic [tnc_pkg::NAME_W-1:0] bottom_ff, bottom_in;
   logic [tnc_pkg::NAME_W-1:0] name_ff, name_in;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   tnc_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [tnc_pkg::DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [tnc_pkg::DEPTH_W-1:0] rsp_peak_ff, rsp_peak_in;
   logic [tnc_pkg::NAME_W-1:0] rsp_etag_ff, rsp_etag_in;

   logic [CW-1:0]              top_p1, top_m1;
   logic                       emit, eod_res, room;
   logic                       wr_en, rd_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [tnc_pkg::NAME_W-1:0] rd_data;

   assign top_p1 = top_ff + 1'b1;
   assign top_m1 = top_ff - 1'b1;
   assign room   = (top_ff < CW'(STACK_DEPTH));

   // stack RAM beside the bottom register: entry i holds the name at depth i+1
   tnc_ram #(
      .WIDTH (tnc_pkg::NAME_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_item.name),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_addr = top_ff[AW-1:0];
   assign rd_addr = top_m1[AW-1:0];

   // sequencer and stack update
   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      peak_in   = peak_ff;
      status_in = status_ff;
      etag_in   = etag_ff;
      bottom_in = bottom_ff;
      name_in   = name_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      emit      = 1'b0;
      eod_res   = 1'b0;
      unique case (state_ff)
         tnc_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               emit  = 1'b1;
               if (q_item.kind == tnc_pkg::OP_EOD) begin
                  // report, then clear per-document state
                  eod_res   = 1'b1;
                  top_in    = '0;
                  peak_in   = '0;
                  status_in = tnc_pkg::ST_RUNNING;
                  etag_in   = '0;
               end else if (status_ff == tnc_pkg::ST_RUNNING) begin
                  unique case (q_item.kind)
                     tnc_pkg::OP_OPEN: begin
                        if (room) begin
                           wr_en  = 1'b1;
                           top_in = top_p1;
                           if (top_p1 > peak_ff) begin
                              peak_in = top_p1;
                           end
                           if (top_ff == '0) begin
                              bottom_in = q_item.name;
                           end
                        end else begin
                           status_in = tnc_pkg::ST_TOO_DEEP;
                           etag_in   = q_item.name;
                        end
                     end
                     tnc_pkg::OP_SELF: begin
                        // push and pop of the same name always match
                        if (room) begin
                           if (top_p1 > peak_ff) begin
                              peak_in = top_p1;
                           end
                        end else begin
                           status_in = tnc_pkg::ST_TOO_DEEP;
                           etag_in   = q_item.name;
                        end
                     end
                     tnc_pkg::OP_CLOSE: begin
                        if (top_ff == '0) begin
                           status_in = tnc_pkg::ST_NO_OPEN;
                           etag_in   = q_item.name;
                        end else begin
                           // fetch top entry, compare next cycle
                           emit     = 1'b0;
                           rd_en    = 1'b1;
                           name_in  = q_item.name;
                           state_in = tnc_pkg::B_CMP;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         tnc_pkg::B_CMP: begin
            emit     = 1'b1;
            top_in   = top_m1;
            state_in = tnc_pkg::B_IDLE;
            if (rd_data != name_ff) begin
               status_in = tnc_pkg::ST_MISMATCH;
               etag_in   = name_ff;
            end
         end
         default: begin
            state_in = tnc_pkg::B_IDLE;
         end
      endcase
   end

   // result assembly
   always_comb begin
      rsp_strobe_in = emit;
      if (eod_res) begin
         rsp_depth_in = tnc_pkg::DEPTH_W'(top_ff);
         rsp_peak_in  = tnc_pkg::DEPTH_W'(peak_ff);
         if (status_ff != tnc_pkg::ST_RUNNING) begin
            rsp_status_in = status_ff;
            rsp_etag_in   = etag_ff;
         end else if (top_ff == '0) begin
            rsp_status_in = tnc_pkg::ST_OK;
            rsp_etag_in   = '0;
         end else begin
            rsp_status_in = tnc_pkg::ST_UNCLOSED;
            rsp_etag_in   = bottom_ff;
         end
      end else begin
         rsp_status_in = status_in;
         rsp_etag_in   = etag_in;
         rsp_depth_in  = tnc_pkg::DEPTH_W'(top_in);
         rsp_peak_in   = tnc_pkg::DEPTH_W'(peak_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tnc_pkg::B_IDLE;
         top_ff        <= '0;
         peak_ff       <= '0;
         status_ff     <= tnc_pkg::ST_RUNNING;
         etag_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         peak_ff       <= peak_in;
         status_ff     <= status_in;
         etag_ff       <= etag_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      bottom_ff     <= bottom_in;
      name_ff       <= name_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_etag_ff   <= rsp_etag_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_max_depth = rsp_peak_ff;
   assign rsp_error_tag = rsp_etag_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_peak_covers_top: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= top_ff)
      else $error("peak depth below current depth");

   a_cmp_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == tnc_pkg::B_CMP |=> rsp_strobe_ff && state_ff == tnc_pkg::B_IDLE)
      else $error("compare step did not deliver a result");

   a_cmp_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == tnc_pkg::B_CMP |-> top_ff != '0)
      else $error("compare step with empty stack");

endmodule

>>> hdl/tag_nesting_checker_core.sv
// ----------------------------------------------------------------------------
// tag_nesting_checker_core
// Checks that markup tag events nest properly, one result per item.
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   -------------------------
//   request   req_end_of_doc/tag_name/is_open/close   start & !busy
//   result    rsp_status/depth/max_depth/error_tag   rsp_strobe, one cycle
//   config    csr_index, csr_wdata                    csr_valid & csr_ready
//
// An item goes through a two-entry queue to the stack engine. Most items
// are handled in the engine's idle state; a close on a non-empty stack in
// a running document also passes the compare state, as the stack RAM read
// is registered. The queue registers the item, and the result is then
// registered at the outputs. busy is high while the queue is full.
// Reset clears stack depth, peak, status and the relevant list; stack RAM
// contents need no clearing. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module tag_nesting_checker_core #(
   parameter int STACK_DEPTH    = 100,
   parameter int RELEVANT_SLOTS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_end_of_doc,
   input  logic [tnc_pkg::NAME_W-1:0]    req_tag_name,
   input  logic                          req_is_open,
   input  logic                          req_is_close,
   // result
   output logic                          rsp_strobe,
   output logic [tnc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tnc_pkg::DEPTH_W-1:0]   rsp_depth,
   output logic [tnc_pkg::DEPTH_W-1:0]   rsp_max_depth,
   output logic [tnc_pkg::NAME_W-1:0]    rsp_error_tag,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tnc_pkg::INDEX_W-1:0]   csr_index,
   input  logic [tnc_pkg::NAME_W-1:0]    csr_wdata
);

   tnc_pkg::item_type front_item;
   tnc_pkg::item_type q_head;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;
   logic              accept;

   assign busy   = q_full;
   assign accept = start & ~busy;

   // classification front
   tnc_front #(
      .RELEVANT_SLOTS (RELEVANT_SLOTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_end_of_doc (req_end_of_doc),
      .req_tag_name   (req_tag_name),
      .req_is_open    (req_is_open),
      .req_is_close   (req_is_close),
      .item           (front_item)
   );

   // decoupling queue
   tnc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // stack engine
   tnc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_head),
      .q_pop         (q_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_depth     (rsp_depth),
      .rsp_max_depth (rsp_max_depth),
      .rsp_error_tag (rsp_error_tag)
   );

endmodule
